// ===== rtl/pdpo_pkg.sv =====
// Shared types, constants and functions of the pitch-driven phase oscillator.
`default_nettype none
package pdpo_pkg;

	localparam int PHASE_BITS   = 24;
	localparam int PERIOD_BITS  = 23;
	localparam int OUT_BITS     = 16;
	localparam int CORDIC_STEPS = 30;
	localparam int DIV_STEPS    = 24;
	localparam int CNT_BITS     = 5;
	localparam int XY_BITS      = 33;
	localparam int Z_BITS       = 32;

	localparam logic signed [XY_BITS-1:0] CORDIC_GAIN = 33'sd652032874;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NEGATIVE = 2'd1,
		ST_ZERO     = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		REG_UNVOICED_OUTPUT = 2'd0,
		REG_STRICT_MODE     = 2'd1,
		REG_UNVOICED_MARKER = 2'd2
	} reg_index_t;

	typedef enum logic [1:0] {
		S_IDLE  = 2'd0,
		S_START = 2'd1,
		S_CALC  = 2'd2,
		S_DONE  = 2'd3
	} state_t;

	// Request from the sequencer to the iterative engine.
	typedef struct packed {
		logic                   start;
		logic [PHASE_BITS-1:0]  phase;
		logic [PERIOD_BITS-1:0] divisor;
	} eng_req_t;

	// Results of the engine, held until the next start.
	typedef struct packed {
		logic                       done;
		logic signed [OUT_BITS-1:0] sine;
		logic signed [OUT_BITS-1:0] cosine;
		logic [PHASE_BITS-1:0]      inc;
	} eng_rsp_t;

	// Arctangent of 2^-i in units of 2^-32 turn.
	function automatic logic [Z_BITS-1:0] atan_turns(input logic [CNT_BITS-1:0] i);
		logic [Z_BITS-1:0] r;
		case (i)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051D;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2E;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2F9;
			5'd15: r = 32'h0000517C;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A2F;
			5'd19: r = 32'h00000517;
			5'd20: r = 32'h0000028B;
			5'd21: r = 32'h00000145;
			5'd22: r = 32'h000000A2;
			5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000028;
			5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A;
			5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000002;
			5'd29: r = 32'h00000001;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Round half up from scale 2^30 to Q1.15 and saturate.
	function automatic logic signed [OUT_BITS-1:0] round_sat(input logic signed [XY_BITS:0] v);
		logic signed [XY_BITS+1:0] t;
		logic signed [XY_BITS+1:0] s;
		logic signed [OUT_BITS-1:0] r;
		t = {v[XY_BITS], v} + 35'sd16384;
		s = t >>> 15;
		if (s > 35'sd32767)
			r = 16'sh7FFF;
		else if (s < -35'sd32768)
			r = 16'sh8000;
		else
			r = s[OUT_BITS-1:0];
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/pdpo_engine.sv =====
// Iterative engine: one CORDIC rotation step and one restoring divide step per cycle.
`default_nettype none
module pdpo_engine
	import pdpo_pkg::*;
(
	input  wire      clk,
	input  wire      arst_n,
	input  eng_req_t req,
	output eng_rsp_t rsp
);

	logic                       busy_q;
	logic                       done_q;
	logic [CNT_BITS-1:0]        cnt_q;
	logic signed [XY_BITS-1:0]  x_q;
	logic signed [XY_BITS-1:0]  y_q;
	logic signed [Z_BITS-1:0]   z_q;
	logic [1:0]                 quad_q;
	logic [PHASE_BITS-1:0]      rem_q;
	logic [PHASE_BITS-1:0]      quo_q;
	logic [PERIOD_BITS-1:0]     div_q;

	logic signed [XY_BITS-1:0]  dx;
	logic signed [XY_BITS-1:0]  dy;
	logic [Z_BITS-1:0]          at;
	logic [PHASE_BITS-1:0]      rem_sh;
	logic                       qbit;
	logic signed [XY_BITS:0]    sin_raw;
	logic signed [XY_BITS:0]    cos_raw;
	logic signed [XY_BITS:0]    xe;
	logic signed [XY_BITS:0]    ye;

	// Shared step datapath.
	always_comb begin
		dx     = y_q >>> cnt_q;
		dy     = x_q >>> cnt_q;
		at     = atan_turns(cnt_q);
		rem_sh = {rem_q[PHASE_BITS-2:0], 1'b0};
		qbit   = (rem_sh >= {1'b0, div_q});
	end

	// Control: counter runs over all rotation steps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_BITS'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q    <= CORDIC_GAIN;
			y_q    <= '0;
			z_q    <= {2'b00, req.phase[PHASE_BITS-3:0], 8'h00};
			quad_q <= req.phase[PHASE_BITS-1:PHASE_BITS-2];
			rem_q  <= PHASE_BITS'(256);
			quo_q  <= '0;
			div_q  <= req.divisor;
		end else if (busy_q) begin
			if (!z_q[Z_BITS-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - $signed(at);
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + $signed(at);
			end
			if (cnt_q < CNT_BITS'(DIV_STEPS)) begin
				rem_q <= qbit ? rem_sh - {1'b0, div_q} : rem_sh;
				quo_q <= {quo_q[PHASE_BITS-2:0], qbit};
			end
		end
	end

	// Quadrant fold and output scaling.
	always_comb begin
		xe = {x_q[XY_BITS-1], x_q};
		ye = {y_q[XY_BITS-1], y_q};
		case (quad_q)
			2'd0: begin cos_raw = xe;  sin_raw = ye;  end
			2'd1: begin cos_raw = -ye; sin_raw = xe;  end
			2'd2: begin cos_raw = -xe; sin_raw = -ye; end
			default: begin cos_raw = ye; sin_raw = -xe; end
		endcase
		rsp.done   = done_q;
		rsp.sine   = round_sat(sin_raw);
		rsp.cosine = round_sat(cos_raw);
		rsp.inc    = (div_q <= PERIOD_BITS'(256)) ? {PHASE_BITS{1'b1}} : quo_q;
	end

endmodule
`default_nettype wire

// ===== rtl/pitch_driven_phase_oscillator_top.sv =====
// Top level of the pitch-driven phase oscillator.
//
// Input stream s_*: one word per sample, tdata holds the signed Q15.8 pitch
// period. Output stream m_*: one word per input word with sine, cosine,
// sawtooth, the period used and a status code. Configuration channel cfg_*:
// register index 0 unvoiced output, 1 strict mode, 2 unvoiced marker; it is
// always ready and should be written only while the block is idle.
// Each word goes from acceptance through the start state, which starts the
// engine, and 30 CORDIC steps in the shared rotation unit, with the 24-step
// divider for the phase increment running alongside, then through the done
// state, which commits it to the output register. The block takes one word
// at a time; it accepts the next word only after the last one is committed.
// The output register holds a finished word while the receiver stalls; the
// next word may be accepted meanwhile, but its result waits until the
// register is free. Reset clears the phase, the held period, the extension
// flag, the configuration registers and the output valid flag.
`default_nettype none
module pitch_driven_phase_oscillator_top
	import pdpo_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [23:0] s_tdata,   // [23:0] pitch_period
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [79:0] m_tdata,   // [15:0] sine, [31:16] cosine, [47:32] sawtooth,
	                               // [70:48] pitch_used, [72:71] status, rest zero
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [1:0]  cfg_index,
	input  wire  [22:0] cfg_data
);

	state_t state_q, state_d;

	logic [15:0]            unv_out_q;
	logic                   strict_q;
	logic [PERIOD_BITS-1:0] marker_q;
	logic [PHASE_BITS-1:0]  phase_q;
	logic [PERIOD_BITS-1:0] held_q;
	logic                   extending_q;
	logic [23:0]            period_q;
	logic                   out_valid_q;
	logic [79:0]            out_data_q;

	eng_req_t req;
	eng_rsp_t rsp;

	logic                   unv;
	logic                   ext_sub;
	logic [PERIOD_BITS-1:0] p_used;
	logic                   commit;
	logic [PHASE_BITS:0]    sum;
	logic [79:0]            word_d;
	logic [PHASE_BITS-1:0]  phase_d;
	logic [PERIOD_BITS-1:0] held_d;
	logic                   extending_d;
	status_t                status;
	logic [15:0]            saw;

	pdpo_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// Period decode with extension of the last voiced period.
	always_comb begin
		unv     = (period_q[PERIOD_BITS-1:0] == marker_q);
		ext_sub = !strict_q && unv && extending_q;
		p_used  = ext_sub ? held_q : period_q[PERIOD_BITS-1:0];
		sum     = {1'b0, phase_q} + {1'b0, rsp.inc};
		saw     = {~phase_q[PHASE_BITS-1], phase_q[PHASE_BITS-2:PHASE_BITS-16]};
	end

	// Result word and state update.
	always_comb begin
		word_d      = '0;
		phase_d     = phase_q;
		held_d      = held_q;
		extending_d = extending_q;
		status      = ST_OK;
		if (period_q[23]) begin
			status = ST_NEGATIVE;
		end else if (p_used == marker_q) begin
			word_d[15:0]  = unv_out_q;
			word_d[31:16] = unv_out_q;
			word_d[47:32] = unv_out_q;
			word_d[70:48] = p_used;
			phase_d       = '0;
		end else if (p_used == '0) begin
			status = ST_ZERO;
		end else begin
			word_d[15:0]  = rsp.sine;
			word_d[31:16] = rsp.cosine;
			word_d[47:32] = saw;
			word_d[70:48] = p_used;
			phase_d       = sum[PHASE_BITS-1:0];
			if (!strict_q) begin
				held_d      = p_used;
				extending_d = 1'b1;
				if (unv && ((phase_q <= PHASE_BITS'(1 << (PHASE_BITS - 1))
				            && sum >= (PHASE_BITS + 1)'(1 << (PHASE_BITS - 1)))
				           || sum[PHASE_BITS]))
					extending_d = 1'b0;
			end
		end
		word_d[72:71] = status;
	end

	// Sequencer next state.
	always_comb begin
		state_d     = state_q;
		s_tready    = 1'b0;
		commit      = 1'b0;
		req.start   = 1'b0;
		req.phase   = phase_q;
		req.divisor = p_used;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid)
					state_d = S_START;
			end
			S_START: begin
				req.start = 1'b1;
				state_d   = S_CALC;
			end
			S_CALC: begin
				if (rsp.done)
					state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || m_tready) begin
					commit  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control and state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			unv_out_q   <= '0;
			strict_q    <= 1'b0;
			marker_q    <= '0;
			phase_q     <= '0;
			held_q      <= '0;
			extending_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				case (cfg_index)
					REG_UNVOICED_OUTPUT: unv_out_q <= cfg_data[15:0];
					REG_STRICT_MODE:     strict_q  <= cfg_data[0];
					REG_UNVOICED_MARKER: marker_q  <= cfg_data;
					default: ;
				endcase
			end
			if (commit) begin
				phase_q     <= phase_d;
				held_q      <= held_d;
				extending_q <= extending_d;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			period_q <= s_tdata;
		if (commit)
			out_data_q <= word_d;
	end

	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

endmodule
`default_nettype wire

// ===== rtl/pdpo_checker.sv =====
// Port-level checks of the pitch-driven phase oscillator and their binding.
`default_nettype none
module pdpo_checker
	import pdpo_pkg::*;
(
	input wire        clk,
	input wire        arst_n,
	input wire        s_tvalid,
	input wire        s_tready,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [79:0] m_tdata
);

	// The block works on one word at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while a word was in flight");

	// A stalled output word is held.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word dropped or changed under stall");

	// Only defined status codes appear.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[72:71] != 2'd3)
		else $error("undefined status code");

	// An error word carries no waveform or period.
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[72:71] != ST_OK |-> m_tdata[70:0] == '0 && m_tdata[79:73] == '0)
		else $error("error word carries data");

endmodule

bind pitch_driven_phase_oscillator_top pdpo_checker u_pdpo_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire
